// ----- rtl/ars_pkg.sv -----
// ars_pkg: shared types and constants for the autorange selector
// register indexes, level status codes and fixed field widths
// no dependencies
package ars_pkg;

   localparam int TIME_W      = 48;
   localparam int READING_W   = 12;
   localparam int LOW_W       = 10;
   localparam int HIGH_W      = 11;
   localparam int HYST_W      = 9;
   localparam int SETTLE_W    = 9;
   localparam int SETTLE_US_W = 19;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int ENABLES_W   = 8;
   localparam int INDEX_W     = 3;
   localparam int STATUS_W    = 2;

   localparam int US_PER_MS = 1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_HYSTERESIS     = 2'd2,
      CSR_SETTLE         = 2'd3
   } csr_index_type;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_WITHIN = 2'b00;
   localparam status_type STATUS_ABOVE  = 2'b01;
   localparam status_type STATUS_BELOW  = 2'b11;

   localparam logic [LOW_W-1:0]       LOW_RESET       = 10'd200;
   localparam logic [HIGH_W-1:0]      HIGH_RESET      = 11'd1800;
   localparam logic [HYST_W-1:0]      HYST_RESET      = 9'd50;
   localparam logic [SETTLE_US_W-1:0] SETTLE_US_RESET = 19'd150000;

endpackage

// ----- rtl/autorange_selector_top.sv -----
// autorange_selector_top: hysteretic auto-ranging over one-hot range drives
// depends on ars_pkg for register indexes, status codes and widths
//
// Usage:
//   req_ channel: one level reading, the auto-enable level and a microsecond
//   timestamp per transfer. rsp_ channel: range enables, range index, level
//   status and a changed flag, exactly one result per request.
//   csr_ channel: register writes (index, data), always ready; write only
//   while no request is in flight.
//   A request passes through the request register and then the result register,
//   which drives rsp_valid. One request can be taken every cycle while rsp_stall
//   is low: the request register feeds the decision logic, which writes the range
//   state and the result register in the same cycle.
//   When rsp_stall is high and the result register is full, the request
//   register holds its item and req_stall rises; nothing is dropped.
//   Synchronous reset restores the register defaults, turns all ranges off,
//   selects range 0, clears the switch time and empties both stages.
module autorange_selector_top #(
   parameter int NUM_RANGES = 8
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ars_pkg::READING_W-1:0]     req_reading_mv,
   input  logic                              req_auto_active,
   input  logic [ars_pkg::TIME_W-1:0]        req_now_us,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ars_pkg::ENABLES_W-1:0]     rsp_range_enables,
   output logic [ars_pkg::INDEX_W-1:0]       rsp_range_index,
   output logic signed [ars_pkg::STATUS_W-1:0] rsp_level_status,
   output logic                              rsp_range_changed,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ars_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ars_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int RW   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
   localparam int EXTW = (RW > ars_pkg::INDEX_W) ? RW : ars_pkg::INDEX_W;
   localparam logic [RW-1:0] TOP_RANGE = RW'(NUM_RANGES - 1);

   // configuration
   logic [ars_pkg::LOW_W-1:0]       low_ff;
   logic [ars_pkg::HIGH_W-1:0]      high_ff;
   logic [ars_pkg::HYST_W-1:0]      hyst_ff;
   logic [ars_pkg::SETTLE_US_W-1:0] settle_us_ff;
   logic [ars_pkg::SETTLE_US_W-1:0] settle_us_in;
   logic                            csr_write;

   // request register
   logic                            s1_valid_ff;
   logic [ars_pkg::READING_W-1:0]   s1_reading_ff;
   logic                            s1_auto_ff;
   logic [ars_pkg::TIME_W-1:0]      s1_now_ff;

   // range state
   logic                            auto_was_on_ff, auto_was_on_in;
   logic [RW-1:0]                   range_ff, range_in;
   logic                            driven_ff, driven_in;
   logic [ars_pkg::TIME_W-1:0]      last_switch_ff, last_switch_in;

   // result register
   logic                            rsp_valid_ff;
   logic [ars_pkg::ENABLES_W-1:0]   enables_ff, enables_in;
   logic [ars_pkg::INDEX_W-1:0]     index_ff, index_in;
   ars_pkg::status_type             status_ff, status_in;
   logic                            changed_ff, changed_in;

   logic                            advance;
   logic                            req_xfer;
   logic [ars_pkg::TIME_W-1:0]      elapsed;
   logic                            settled;
   logic [ars_pkg::READING_W-1:0]   up_limit;
   logic [ars_pkg::READING_W:0]     reading_plus_hyst;
   logic                            step_up;
   logic                            step_down;
   logic [EXTW-1:0]                 range_ext;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign settle_us_in = ars_pkg::SETTLE_US_W'(csr_wdata[ars_pkg::SETTLE_W-1:0])
                       * ars_pkg::SETTLE_US_W'(ars_pkg::US_PER_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= ars_pkg::LOW_RESET;
         high_ff      <= ars_pkg::HIGH_RESET;
         hyst_ff      <= ars_pkg::HYST_RESET;
         settle_us_ff <= ars_pkg::SETTLE_US_RESET;
      end else if (csr_write) begin
         case (ars_pkg::csr_index_type'(csr_index))
            ars_pkg::CSR_LOW_THRESHOLD: begin
               low_ff <= csr_wdata[ars_pkg::LOW_W-1:0];
            end
            ars_pkg::CSR_HIGH_THRESHOLD: begin
               high_ff <= csr_wdata[ars_pkg::HIGH_W-1:0];
            end
            ars_pkg::CSR_HYSTERESIS: begin
               hyst_ff <= csr_wdata[ars_pkg::HYST_W-1:0];
            end
            ars_pkg::CSR_SETTLE: begin
               settle_us_ff <= settle_us_in;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake: the request stage moves on when the result register is empty or being taken
   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_xfer  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_reading_ff <= req_reading_mv;
         s1_auto_ff    <= req_auto_active;
         s1_now_ff     <= req_now_us;
      end
   end

   // decision logic
   assign elapsed  = s1_now_ff - last_switch_ff;
   assign settled  = elapsed >= ars_pkg::TIME_W'(settle_us_ff);
   assign up_limit = ars_pkg::READING_W'(high_ff) + ars_pkg::READING_W'(hyst_ff);
   // reading < low - hyst, rearranged to stay unsigned
   assign reading_plus_hyst = (ars_pkg::READING_W+1)'(s1_reading_ff)
                            + (ars_pkg::READING_W+1)'(hyst_ff);
   assign step_up   = (s1_reading_ff > up_limit) & (range_ff < TOP_RANGE);
   assign step_down = (reading_plus_hyst < (ars_pkg::READING_W+1)'(low_ff))
                    & (range_ff != '0);

   always_comb begin
      auto_was_on_in = auto_was_on_ff;
      range_in       = range_ff;
      driven_in      = driven_ff;
      last_switch_in = last_switch_ff;
      changed_in     = 1'b0;

      if (ars_pkg::READING_W'(low_ff) > s1_reading_ff) begin
         status_in = ars_pkg::STATUS_BELOW;
      end else if (s1_reading_ff > ars_pkg::READING_W'(high_ff)) begin
         status_in = ars_pkg::STATUS_ABOVE;
      end else begin
         status_in = ars_pkg::STATUS_WITHIN;
      end

      if (s1_auto_ff && !auto_was_on_ff) begin
         range_in       = '0;
         driven_in      = 1'b1;
         last_switch_in = s1_now_ff;
         auto_was_on_in = 1'b1;
         changed_in     = 1'b1;
      end else if (!s1_auto_ff && auto_was_on_ff) begin
         driven_in      = 1'b0;
         auto_was_on_in = 1'b0;
         changed_in     = 1'b1;
      end else if (s1_auto_ff && settled) begin
         if (step_up) begin
            range_in       = range_ff + RW'(1);
            last_switch_in = s1_now_ff;
            changed_in     = 1'b1;
         end else if (step_down) begin
            range_in       = range_ff - RW'(1);
            last_switch_in = s1_now_ff;
            changed_in     = 1'b1;
         end
      end

      range_ext = EXTW'(range_in);
      index_in  = range_ext[ars_pkg::INDEX_W-1:0];
      // only the first eight drives are visible on the port
      for (int i = 0; i < ars_pkg::ENABLES_W; i++) begin
         enables_in[i] = driven_in & (range_ext == EXTW'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_was_on_ff <= 1'b0;
         range_ff       <= '0;
         driven_ff      <= 1'b0;
         last_switch_ff <= '0;
      end else if (advance) begin
         auto_was_on_ff <= auto_was_on_in;
         range_ff       <= range_in;
         driven_ff      <= driven_in;
         last_switch_ff <= last_switch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         enables_ff <= enables_in;
         index_ff   <= index_in;
         status_ff  <= status_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_enables = enables_ff;
   assign rsp_range_index   = index_ff;
   assign rsp_level_status  = status_ff;
   assign rsp_range_changed = changed_ff;

endmodule
